// ===== rtl/ffba_pkg.sv =====
// Shared types and constants for the first-fit bitmap allocator.
package ffba_pkg;

  localparam int WORD_W  = 16;
  localparam int WORD_SH = 4;
  localparam int POS_W   = 12;
  localparam int PTR_W   = POS_W - WORD_SH;

  localparam logic [10:0] CELLS_RESET = 11'd1024;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_MARK,
    ST_FINISH
  } ffba_state_t;

  typedef struct packed {
    logic accept;
    logic load_scan;
    logic load_mark;
    logic rd_en;
    logic wr;
    logic clr_wr;
    logic res_load;
  } ffba_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_alloc;
    logic trivial;
    logic more;
    logic rd_valid;
    logic rd_last;
    logic hit;
  } ffba_sts_t;

endpackage

// ===== rtl/ffba_ctrl.sv =====
// Controller state machine for the first-fit bitmap allocator.
module ffba_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  ffba_pkg::ffba_sts_t  sts,
  output ffba_pkg::ffba_cmd_t  cmd
);

  ffba_pkg::ffba_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ffba_pkg::ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    unique case (state)
      ffba_pkg::ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) state_next = ffba_pkg::ST_IDLE;
      end
      ffba_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ffba_pkg::ST_DISPATCH;
        end
      end
      ffba_pkg::ST_DISPATCH: begin
        if (sts.trivial) begin
          state_next = ffba_pkg::ST_FINISH;
        end else if (sts.is_alloc) begin
          cmd.load_scan = 1'b1;
          state_next    = ffba_pkg::ST_SCAN;
        end else begin
          cmd.load_mark = 1'b1;
          state_next    = ffba_pkg::ST_MARK;
        end
      end
      ffba_pkg::ST_SCAN: begin
        cmd.rd_en = sts.more && !(sts.rd_valid && sts.hit);
        if (sts.rd_valid && sts.hit) begin
          cmd.load_mark = 1'b1;
          state_next    = ffba_pkg::ST_MARK;
        end else if (sts.rd_valid && sts.rd_last) begin
          state_next = ffba_pkg::ST_FINISH;
        end
      end
      ffba_pkg::ST_MARK: begin
        cmd.rd_en = sts.more;
        cmd.wr    = sts.rd_valid;
        if (sts.rd_valid && sts.rd_last) state_next = ffba_pkg::ST_FINISH;
      end
      ffba_pkg::ST_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.res_load = 1'b1;
          state_next   = ffba_pkg::ST_IDLE;
        end
      end
      default: state_next = ffba_pkg::ST_CLEAR;
    endcase
  end

endmodule

// ===== rtl/ffba_dp.sv =====
// Datapath of the first-fit bitmap allocator: free map memory, word scan and range update.
module ffba_dp #(
  parameter int POOL_CELLS = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ffba_pkg::ffba_cmd_t  cmd,
  output ffba_pkg::ffba_sts_t  sts,
  input  logic                 cfg_we,
  input  logic [10:0]          cfg_wdata,
  input  logic                 operation,
  input  logic [9:0]           start_cell,
  input  logic [10:0]          length,
  output logic                 found,
  output logic [9:0]           alloc_start,
  output logic [10:0]          freed_count
);

  localparam int WW    = ffba_pkg::WORD_W;
  localparam int SH    = ffba_pkg::WORD_SH;
  localparam int PW    = ffba_pkg::POS_W;
  localparam int TW    = ffba_pkg::PTR_W;
  localparam int WORDS = (POOL_CELLS + WW - 1) / WW;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;

  logic [WW-1:0] mem [WORDS];
  logic [WW-1:0] rdata;
  logic [AW-1:0] clr_addr;

  logic [10:0]        cells;
  logic [PW-1:0]      n;
  ffba_pkg::op_t      op_q;
  logic [10:0]        len_q;
  logic [PW-1:0]      lo_q;
  logic [PW-1:0]      hi_q;
  logic [PW-1:0]      run_q;
  logic [PW-1:0]      freed_q;
  logic               found_q;
  logic [PW-1:0]      astart_q;

  logic [TW-1:0]      rp;
  logic [TW-1:0]      end_q;
  logic               more_q;
  logic               rd_valid_q;
  logic [TW-1:0]      rd_word_q;

  logic [PW-1:0]      req_sum;
  logic [PW-1:0]      req_hi;
  logic [PW-1:0]      n_m1;
  logic [PW-1:0]      mark_lo;
  logic [PW-1:0]      mark_hi;
  logic [PW-1:0]      mark_hm1;

  logic [PW-1:0]      base;
  logic [PW-1:0]      pos  [WW];
  logic [PW-1:0]      runs [WW];
  logic [WW-1:0]      fbit;
  logic [WW-1:0]      mask;
  logic               hit;
  logic [PW-1:0]      hit_start;
  logic [WW-1:0]      wdata;
  logic [SH:0]        pop;

  always_comb begin
    n = (32'(cells) > POOL_CELLS) ? PW'(POOL_CELLS) : PW'(cells);
    req_sum  = PW'(start_cell) + PW'(length);
    req_hi   = (req_sum > n) ? n : req_sum;
    n_m1     = n - PW'(1);
    mark_lo  = (op_q == ffba_pkg::OP_ALLOC) ? hit_start : lo_q;
    mark_hi  = (op_q == ffba_pkg::OP_ALLOC) ? hit_start + PW'(len_q) : hi_q;
    mark_hm1 = mark_hi - PW'(1);
  end

  // per-word scan and update
  always_comb begin
    base = PW'(rd_word_q) << SH;
    for (int j = 0; j < WW; j++) begin
      pos[j]  = base + PW'(j);
      fbit[j] = rdata[j] && (pos[j] < n);
      mask[j] = (pos[j] >= lo_q) && (pos[j] < hi_q);
    end
    for (int j = 0; j < WW; j++) begin
      runs[j] = run_q + PW'(j + 1);
      for (int k = 0; k <= j; k++) begin
        if (!fbit[k]) runs[j] = PW'(j - k);
      end
    end
    hit       = 1'b0;
    hit_start = '0;
    for (int j = WW - 1; j >= 0; j--) begin
      if (fbit[j] && (runs[j] >= PW'(len_q))) begin
        hit       = 1'b1;
        hit_start = pos[j] + PW'(1) - PW'(len_q);
      end
    end
    wdata = (op_q == ffba_pkg::OP_ALLOC) ? (rdata & ~mask) : (rdata | mask);
    pop   = '0;
    for (int j = 0; j < WW; j++) begin
      pop = pop + (SH+1)'(mask[j] & ~rdata[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cells      <= ffba_pkg::CELLS_RESET;
      clr_addr   <= '0;
      rd_valid_q <= 1'b0;
      more_q     <= 1'b0;
    end else begin
      if (cfg_we) cells <= cfg_wdata;
      if (cmd.clr_wr) clr_addr <= clr_addr + AW'(1);
      rd_valid_q <= cmd.rd_en;
      if (cmd.load_scan || cmd.load_mark) begin
        more_q <= 1'b1;
      end else if (cmd.rd_en && (rp == end_q)) begin
        more_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      mem[clr_addr] <= '1;
    end else if (cmd.wr) begin
      mem[AW'(rd_word_q)] <= wdata;
    end
    if (cmd.rd_en) rdata <= mem[AW'(rp)];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q     <= ffba_pkg::op_t'(operation);
      len_q    <= length;
      lo_q     <= PW'(start_cell);
      hi_q     <= req_hi;
      freed_q  <= '0;
      found_q  <= 1'b0;
      astart_q <= '0;
    end else begin
      if (cmd.load_mark && op_q == ffba_pkg::OP_ALLOC) begin
        lo_q     <= mark_lo;
        hi_q     <= mark_hi;
        found_q  <= 1'b1;
        astart_q <= hit_start;
      end
      if (cmd.wr && op_q == ffba_pkg::OP_FREE) freed_q <= freed_q + PW'(pop);
    end
    if (cmd.load_scan) begin
      rp    <= '0;
      end_q <= n_m1[PW-1:SH];
      run_q <= '0;
    end else if (cmd.load_mark) begin
      rp    <= mark_lo[PW-1:SH];
      end_q <= mark_hm1[PW-1:SH];
    end else begin
      if (cmd.rd_en) rp <= rp + TW'(1);
      if (rd_valid_q) run_q <= runs[WW-1];
    end
    rd_word_q <= rp;
    if (cmd.res_load) begin
      found       <= found_q;
      alloc_start <= astart_q[9:0];
      freed_count <= freed_q[10:0];
    end
  end

  always_comb begin
    sts.clr_last = (clr_addr == AW'(WORDS - 1));
    sts.is_alloc = (op_q == ffba_pkg::OP_ALLOC);
    sts.trivial  = (op_q == ffba_pkg::OP_ALLOC) ? ((len_q == '0) || (PW'(len_q) > n))
                                                : (lo_q >= hi_q);
    sts.more     = more_q;
    sts.rd_valid = rd_valid_q;
    sts.rd_last  = (rd_word_q == end_q);
    sts.hit      = hit;
  end

endmodule

// ===== rtl/first_fit_bitmap_allocator.sv =====
// Top level of the first-fit bitmap allocator.
//
// Requests come in on in_valid/in_ready with operation, start_cell and length;
// one result per request leaves on out_valid/out_ready with found, alloc_start
// and freed_count. cfg_we/cfg_wdata set the number of managed cells; the user
// must write them only while idle, as the block itself does not enforce this.
// The free map lives in a 16-bit-wide memory, one word per cycle. Allocate:
// setup, then a scan word by word from word 0 until the first fitting run or
// the last word, then marking the words of a found run, then posting the result.
// Free: setup, then an update of each word touched by the range, then posting
// the result. Zero-length or out-of-range requests skip the memory and go
// straight to posting their result. in_ready returns the cycle after a result
// is posted. One request is worked on at a time; the next can be accepted
// while the previous result waits in the output register. If the receiver
// stalls with a result pending, the block holds the finished result of the
// next request internally until the output register frees up.
// After reset the memory is set to all free, one word per cycle, during
// which in_ready stays low.
module first_fit_bitmap_allocator #(
  parameter int POOL_CELLS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [10:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation,
  input  logic [9:0]  start_cell,
  input  logic [10:0] length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        found,
  output logic [9:0]  alloc_start,
  output logic [10:0] freed_count
);

  ffba_pkg::ffba_cmd_t cmd;
  ffba_pkg::ffba_sts_t sts;

  ffba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ffba_dp #(
    .POOL_CELLS (POOL_CELLS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .operation   (operation),
    .start_cell  (start_cell),
    .length      (length),
    .found       (found),
    .alloc_start (alloc_start),
    .freed_count (freed_count)
  );

endmodule

// ===== tb/tb_first_fit_bitmap_allocator.sv =====
// Self-checking testbench for the first-fit bitmap allocator: directed and random requests, predicted results.
module tb_first_fit_bitmap_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POOL         = 1024;
  localparam int QUIET_LIMIT  = 3000;
  localparam int SETTLE_WAIT  = 100;

  typedef struct {
    ffba_pkg::op_t op;
    logic [9:0]    start;
    logic [10:0]   len;
  } alloc_req_t;

  typedef struct {
    logic        found;
    logic [9:0]  start;
    logic [10:0] freed;
  } alloc_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [10:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        operation = 1'b0;
  logic [9:0]  start_cell = '0;
  logic [10:0] length = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        found;
  logic [9:0]  alloc_start;
  logic [10:0] freed_count;

  alloc_req_t    pending_requests[$];
  alloc_result_t expected_results[$];
  alloc_req_t    next_req;

  logic free_map [POOL];
  int   cell_limit = int'(ffba_pkg::CELLS_RESET);
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  int   fail_count = 0;
  int   quiet_cycles = 0;
  bit   req_taken = 1'b0;

  first_fit_bitmap_allocator DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .operation  (operation),
    .start_cell (start_cell),
    .length     (length),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .found      (found),
    .alloc_start(alloc_start),
    .freed_count(freed_count)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Applies one request to the free map and returns the result it should produce.
  function automatic alloc_result_t apply_request(ffba_pkg::op_t op, logic [9:0] start,
                                                  logic [10:0] len);
    alloc_result_t res;
    int managed;
    int run_start;
    int stop;
    res = '{1'b0, 10'd0, 11'd0};
    managed = (cell_limit > POOL) ? POOL : cell_limit;
    run_start = 0;
    if (op == ffba_pkg::OP_ALLOC) begin
      if (len != 0) begin
        for (int p = 0; p < managed; p++) begin
          if (!free_map[p]) begin
            run_start = p + 1;
          end else if (p - run_start + 1 == int'(len)) begin
            res.found = 1'b1;
            break;
          end
        end
      end
      if (res.found) begin
        res.start = run_start[9:0];
        for (int i = 0; i < int'(len); i++) free_map[run_start + i] = 1'b0;
      end
    end else begin
      stop = int'(start) + int'(len);
      if (stop > managed) stop = managed;
      for (int i = int'(start); i < stop; i++) begin
        if (!free_map[i]) begin
          res.freed++;
          free_map[i] = 1'b1;
        end
      end
    end
    return res;
  endfunction

  // Mostly small runs so the pool fills and fragments; a few zero, whole-pool and oversize lengths.
  function automatic alloc_req_t random_request(int managed);
    alloc_req_t r;
    int pick;
    pick = $urandom_range(99);
    r.op = (pick < 55) ? ffba_pkg::OP_ALLOC : ffba_pkg::OP_FREE;
    r.start = 10'($urandom_range(1023));
    if (r.op == ffba_pkg::OP_FREE && managed > 0 && $urandom_range(99) < 80)
      r.start = 10'($urandom_range(managed - 1));
    pick = $urandom_range(99);
    if (pick < 65) begin
      r.len = 11'($urandom_range(16, 1));
    end else if (pick < 88) begin
      r.len = 11'($urandom_range(128, 17));
    end else if (pick < 96) begin
      r.len = 11'($urandom_range(1024, 129));
    end else begin
      case ($urandom_range(3))
        0: r.len = 11'd0;
        1: r.len = 11'd1024;
        2: r.len = 11'($urandom_range(2047, 1025));
        default: begin
          r.len = 11'd1024;
          r.start = '0;
        end
      endcase
    end
    return r;
  endfunction

  task automatic push_req(ffba_pkg::op_t op, int start, int len);
    alloc_req_t r;
    r.op = op;
    r.start = start[9:0];
    r.len = len[10:0];
    pending_requests.push_back(r);
  endtask

  task automatic wait_drained();
    while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  task automatic run_phase(int cells, int idle_pct, int stall, int count);
    int managed;
    wait_drained();
    repeat (SETTLE_WAIT) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= cells[10:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    cell_limit = cells;
    send_idle_pct = idle_pct;
    stall_pct = stall;
    managed = (cells > POOL) ? POOL : cells;
    repeat (count) pending_requests.push_back(random_request(managed));
  endtask

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_req = pending_requests.pop_front();
        in_valid <= 1'b1;
        operation <= next_req.op;
        start_cell <= next_req.start;
        length <= next_req.len;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // result monitor and watchdog
  always @(posedge clk) begin : monitor
    alloc_result_t want;
    req_taken = 1'b0;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding: found=%0d alloc_start=%0d freed_count=%0d",
                 found, alloc_start, freed_count);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, found);
            fail_count++;
          end
          if (alloc_start !== want.start) begin
            $error("alloc_start: expected %0d, got %0d", want.start, alloc_start);
            fail_count++;
          end
          if (freed_count !== want.freed) begin
            $error("freed_count: expected %0d, got %0d", want.freed, freed_count);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        req_taken = 1'b1;
        expected_results.push_back(
          apply_request(ffba_pkg::op_t'(operation), start_cell, length));
      end
      if ((out_valid && out_ready) || (in_valid && in_ready) || cfg_we) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("first_fit_bitmap_allocator verification failed");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < POOL; i++) free_map[i] = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: zero and oversize lengths, full pool, holes, clamped frees
    push_req(ffba_pkg::OP_ALLOC, 0, 0);
    push_req(ffba_pkg::OP_ALLOC, 1023, 1);
    push_req(ffba_pkg::OP_ALLOC, 0, 1024);
    push_req(ffba_pkg::OP_FREE, 0, 1);
    push_req(ffba_pkg::OP_ALLOC, 0, 1024);
    push_req(ffba_pkg::OP_ALLOC, 0, 1);
    push_req(ffba_pkg::OP_FREE, 1023, 2047);
    push_req(ffba_pkg::OP_FREE, 0, 0);
    push_req(ffba_pkg::OP_FREE, 1000, 24);
    push_req(ffba_pkg::OP_ALLOC, 0, 25);
    push_req(ffba_pkg::OP_FREE, 512, 1);
    push_req(ffba_pkg::OP_ALLOC, 0, 2);
    push_req(ffba_pkg::OP_ALLOC, 0, 1);
    push_req(ffba_pkg::OP_FREE, 0, 1024);
    push_req(ffba_pkg::OP_ALLOC, 0, 2047);
    push_req(ffba_pkg::OP_ALLOC, 0, 1023);
    push_req(ffba_pkg::OP_ALLOC, 0, 1);
    push_req(ffba_pkg::OP_FREE, 1023, 1024);
    push_req(ffba_pkg::OP_FREE, 341, 682);
    push_req(ffba_pkg::OP_ALLOC, 682, 682);
    push_req(ffba_pkg::OP_FREE, 0, 1024);

    run_phase(1024, 0, 0, 400);
    run_phase(2047, 63, 0, 300);
    run_phase(100, 0, 63, 300);
    run_phase(0, 17, 17, 60);
    run_phase(1, 0, 0, 80);
    run_phase(37, 63, 0, 200);
    run_phase(1024, 17, 17, 350);
    run_phase(600, 0, 63, 160);

    wait_drained();
    repeat (SETTLE_WAIT) @(negedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("first_fit_bitmap_allocator verification clean");
    end else begin
      $display("first_fit_bitmap_allocator verification failed");
    end
    $finish;
  end

endmodule
